@@ rtl/ais_pkg.sv @@
`timescale 1ns / 1ps

package ais_pkg;

   // Fixed widths of the payload fields
   localparam int KeyW = 64;
   localparam int PosW = 7;

   typedef logic [KeyW-1:0] key_type;
   typedef logic [PosW-1:0] pos_type;

   localparam key_type SignBit = {1'b1, {(KeyW-1){1'b0}}};

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;      // place the broadcast key into the sorted chain
      logic shift_down;  // every cell takes the contents of its upper neighbor
   } cell_ctrl_type;

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // Order-preserving transform: fold -0 onto +0, invert negatives,
   // set the sign bit of positives; then compare as unsigned.
   function automatic key_type order_key(input key_type bits);
      key_type b;
      b = (bits == SignBit) ? '0 : bits;
      if (b[KeyW-1]) begin
         return ~b;
      end
      return b | SignBit;
   endfunction

endpackage

@@ rtl/argsort_index_tiebreak.sv @@
`timescale 1ns / 1ps

// Argsort with position tie-break.
// Input channel (req_*): one IEEE-754 double bit pattern per beat, req_last_in
// on the final beat of a set. A value beat can be taken every cycle while loading:
// an insertion chain of MAX_N cells places each key in sorted order on arrival,
// so the set is sorted once its last value is in. Values beyond MAX_N are dropped and
// flagged.
// Result channel (rsp_*): after the last beat, the chain drains from its low
// end one cell per cycle unless the output is stalled; each beat carries the
// 1-based arrival position of the next value in ascending order, rsp_last_out
// on the final one, and rsp_overflow on every beat of a run that lost values.
// After the edge that took the last value, the output register loads from the
// bottom cell; a run of n results then leaves at one beat per cycle while
// rsp_stall is low. The input is stalled during the drain, as the cell chain
// shifts down; the next set may load while the final result still waits.
// A stalled rsp beat holds its payload and holds the drain in place.
// Reset (synchronous, active high) empties the chain count, clears the
// overflow flags and the output valid flag, and returns to loading.
module argsort_index_tiebreak #(
   parameter int MAX_N = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value_bits,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_position,
   output logic        rsp_last_out,
   output logic        rsp_overflow
);

   localparam int CntW = $clog2(MAX_N + 1);

   ais_pkg::state_type     state_ff, state_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic                   overflow_ff, overflow_in;
   logic                   run_ovf_ff, run_ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ais_pkg::pos_type       rsp_pos_ff, rsp_pos_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   accept;
   logic                   full;
   logic                   emit;
   ais_pkg::cell_ctrl_type ctrl;
   ais_pkg::key_type       new_key;
   ais_pkg::pos_type       new_pos;

   ais_pkg::key_type       cell_key [MAX_N];
   ais_pkg::pos_type       cell_pos [MAX_N];
   logic                   cell_gt  [MAX_N];
   logic                   cell_occ [MAX_N];

   assign accept  = req_valid && !req_stall;
   assign full    = (count_ff == CntW'(MAX_N));
   assign new_key = ais_pkg::order_key(req_value_bits);
   assign new_pos = ais_pkg::pos_type'(count_ff) + ais_pkg::pos_type'(1);
   // Advance the drain whenever the output register is free or being taken
   assign emit    = (state_ff == ais_pkg::ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ais_pkg::ST_LOAD: begin
            if (accept && req_last_in) begin
               state_in = ais_pkg::ST_DRAIN;
            end
         end
         ais_pkg::ST_DRAIN: begin
            if (emit && count_ff == CntW'(1)) begin
               state_in = ais_pkg::ST_LOAD;
            end
         end
         default: state_in = ais_pkg::ST_LOAD;
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      req_stall       = 1'b1;
      ctrl.insert     = 1'b0;
      ctrl.shift_down = 1'b0;
      unique case (state_ff)
         ais_pkg::ST_LOAD: begin
            req_stall   = 1'b0;
            ctrl.insert = accept && !full;
         end
         ais_pkg::ST_DRAIN: begin
            ctrl.shift_down = emit;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // Count of occupied cells; also the number of results left in a drain
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      run_ovf_in  = run_ovf_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CntW'(1);
      end else if (emit) begin
         count_in = count_ff - CntW'(1);
      end
      if (accept) begin
         if (req_last_in) begin
            // latch the flag for the run and start the next set clean
            run_ovf_in  = overflow_ff || full;
            overflow_in = 1'b0;
         end else if (full) begin
            overflow_in = 1'b1;
         end
      end
   end

   // Output register: load from the bottom cell, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = cell_pos[0];
         rsp_last_in  = (count_ff == CntW'(1));
         rsp_ovf_in   = run_ovf_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ais_pkg::ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         run_ovf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         run_ovf_ff   <= run_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // Insertion chain: cell 0 holds the smallest key
   for (genvar i = 0; i < MAX_N; i++) begin : g_cell
      assign cell_occ[i] = (CntW'(i) < count_ff);

      if (i == 0) begin : g_bottom
         ais_cell u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .new_key      (new_key),
            .new_pos      (new_pos),
            .occ          (cell_occ[i]),
            .prev_occ     (1'b1),
            .prev_greater (1'b0),
            .prev_key     (new_key),
            .prev_pos     (new_pos),
            .next_key     (cell_key[i+1]),
            .next_pos     (cell_pos[i+1]),
            .key          (cell_key[i]),
            .pos          (cell_pos[i]),
            .greater      (cell_gt[i])
         );
      end else if (i == MAX_N - 1) begin : g_top
         ais_cell u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .new_key      (new_key),
            .new_pos      (new_pos),
            .occ          (cell_occ[i]),
            .prev_occ     (cell_occ[i-1]),
            .prev_greater (cell_gt[i-1]),
            .prev_key     (cell_key[i-1]),
            .prev_pos     (cell_pos[i-1]),
            .next_key     (cell_key[i]),
            .next_pos     (cell_pos[i]),
            .key          (cell_key[i]),
            .pos          (cell_pos[i]),
            .greater      (cell_gt[i])
         );
      end else begin : g_mid
         ais_cell u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .new_key      (new_key),
            .new_pos      (new_pos),
            .occ          (cell_occ[i]),
            .prev_occ     (cell_occ[i-1]),
            .prev_greater (cell_gt[i-1]),
            .prev_key     (cell_key[i-1]),
            .prev_pos     (cell_pos[i-1]),
            .next_key     (cell_key[i+1]),
            .next_pos     (cell_pos[i+1]),
            .key          (cell_key[i]),
            .pos          (cell_pos[i]),
            .greater      (cell_gt[i])
         );
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_last_out = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

   // A drain never runs on an empty chain
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ais_pkg::ST_DRAIN |-> count_ff != '0)
      else $error("drain with empty chain");

   // The count never exceeds the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_N))
      else $error("cell count beyond chain length");

   // A taken last value closes the input for the drain
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_in |=> req_stall)
      else $error("input open after last value");

   // Every result names a real position
   a_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_position != '0 && rsp_position <= 7'(MAX_N))
      else $error("result position out of range");

endmodule

@@ rtl/ais_cell.sv @@
`timescale 1ns / 1ps

module ais_cell (
   input  logic                  clock,
   input  ais_pkg::cell_ctrl_type ctrl,
   input  ais_pkg::key_type      new_key,
   input  ais_pkg::pos_type      new_pos,
   input  logic                  occ,
   input  logic                  prev_occ,
   input  logic                  prev_greater,
   input  ais_pkg::key_type      prev_key,
   input  ais_pkg::pos_type      prev_pos,
   input  ais_pkg::key_type      next_key,
   input  ais_pkg::pos_type      next_pos,
   output ais_pkg::key_type      key,
   output ais_pkg::pos_type      pos,
   output logic                  greater
);

   ais_pkg::key_type key_ff, key_in;
   ais_pkg::pos_type pos_ff, pos_in;
   logic             take_prev;
   logic             take_new;

   // Strictly greater keeps equal keys in arrival order
   assign greater   = occ && (key_ff > new_key);
   assign take_prev = ctrl.insert && prev_greater;
   assign take_new  = ctrl.insert && !prev_greater && (greater || (!occ && prev_occ));

   always_comb begin
      key_in = key_ff;
      pos_in = pos_ff;
      if (ctrl.shift_down) begin
         key_in = next_key;
         pos_in = next_pos;
      end else if (take_prev) begin
         key_in = prev_key;
         pos_in = prev_pos;
      end else if (take_new) begin
         key_in = new_key;
         pos_in = new_pos;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pos_ff <= pos_in;
   end

   assign key = key_ff;
   assign pos = pos_ff;

endmodule

@@ sim/argsort_index_tiebreak_tb.sv @@
`timescale 1ns / 1ps

module argsort_index_tiebreak_tb;

   localparam int CAPACITY     = 64;
   localparam int QUIET_LIMIT  = 4000;  // cycles without any beat before giving up
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 16;

   // One input beat as queued for the driver
   typedef struct packed {
      ais_pkg::key_type value_bits;
      logic             last_in;
   } value_beat_type;

   // One predicted result beat
   typedef struct packed {
      ais_pkg::pos_type position;
      logic             last_out;
      logic             overflow;
   } order_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_value_bits = '0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_position;
   logic        rsp_last_out;
   logic        rsp_overflow;

   value_beat_type value_feed[$];   // beats still to be offered
   order_beat_type order_due[$];    // positions expected, oldest first

   // Predictor state: sorted keys with their arrival positions
   ais_pkg::key_type key_tab[CAPACITY];
   ais_pkg::pos_type pos_tab[CAPACITY];
   int          kept = 0;
   logic        dropped = 1'b0;

   int          beats_in = 0;        // accepted input beats
   int          stage_one_at = 0;
   int          stage_two_at = 0;
   int          pressure_after = 0;  // beats_in value that arms the hold-off
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   int          mismatch_count = 0;
   value_beat_type next_beat;
   order_beat_type want;

   argsort_index_tiebreak #(.MAX_N(CAPACITY)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value_bits (req_value_bits),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_position   (rsp_position),
      .rsp_last_out   (rsp_last_out),
      .rsp_overflow   (rsp_overflow)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Idle pattern: sender 27% / receiver 56%, then swapped, then none.
   function automatic int idle_stage();
      if (beats_in < stage_one_at) return 0;
      if (beats_in < stage_two_at) return 1;
      return 2;
   endfunction

   function automatic int send_idle_pct();
      case (idle_stage())
         0: return 27;
         1: return 56;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct();
      case (idle_stage())
         0: return 56;
         1: return 27;
         default: return 0;
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Fold -0 onto +0, then map the double onto an unsigned ordering key.
   function automatic ais_pkg::key_type sort_key(input ais_pkg::key_type bits);
      ais_pkg::key_type k;
      k = (bits == ais_pkg::SignBit) ? '0 : bits;
      if (k[63]) return ~k;
      return k | ais_pkg::SignBit;
   endfunction

   // Insert one accepted value into the sorted table; on the last beat of a
   // set, queue the positions in ascending order and start a new set.
   task automatic absorb_value(input ais_pkg::key_type bits, input logic is_last);
      ais_pkg::key_type k;
      int               slot;
      order_beat_type   r;
      k = sort_key(bits);
      if (kept < CAPACITY) begin
         slot = kept;
         // equal keys stay behind earlier arrivals
         while (slot > 0 && key_tab[slot-1] > k) begin
            key_tab[slot] = key_tab[slot-1];
            pos_tab[slot] = pos_tab[slot-1];
            slot--;
         end
         key_tab[slot] = k;
         pos_tab[slot] = ais_pkg::pos_type'(kept + 1);
         kept++;
      end else begin
         dropped = 1'b1;
      end
      if (is_last) begin
         for (int j = 0; j < kept; j++) begin
            r.position = pos_tab[j];
            r.last_out = (j == kept - 1);
            r.overflow = dropped;
            order_due.push_back(r);
         end
         kept = 0;
         dropped = 1'b0;
      end
   endtask

   // Random double pattern: raw bits, small integers for ties, specials,
   // and finite values of any magnitude.
   function automatic ais_pkg::key_type pick_value();
      logic [51:0] mant;
      logic [10:0] expo;
      mant = 52'({$urandom, $urandom});
      expo = 11'($urandom_range(2046));
      case ($urandom_range(3))
         0: return {$urandom, $urandom};
         1: return $realtobits(real'($urandom_range(8)) - 4.0);
         2: begin
            case ($urandom_range(5))
               0: return 64'h0000_0000_0000_0000;
               1: return ais_pkg::SignBit;
               2: return 64'h7FF0_0000_0000_0000;
               3: return 64'hFFF0_0000_0000_0000;
               4: return 64'h0000_0000_0000_0001;
               default: return 64'h8000_0000_0000_0001;
            endcase
         end
         default: return {1'($urandom_range(1)), expo, mant};
      endcase
   endfunction

   task automatic queue_beat(input ais_pkg::key_type bits, input logic is_last);
      value_beat_type b;
      b.value_bits = bits;
      b.last_in    = is_last;
      value_feed.push_back(b);
   endtask

   task automatic queue_set(input int count);
      for (int k = 0; k < count; k++) queue_beat(pick_value(), k == count - 1);
   endtask

   // Driver: take the accepted beat into the predictor, then offer the next
   // one or idle. Hold the payload while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_value(req_value_bits, req_last_in);
            beats_in <= beats_in + 1;
         end
         if (!req_valid || !req_stall) begin
            if (value_feed.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
               next_beat = value_feed.pop_front();
               req_valid      <= 1'b1;
               req_value_bits <= next_beat.value_bits;
               req_last_in    <= next_beat.last_in;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off once the big overflowing
   // set starts to drain, so the sender keeps pushing into a stopped block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_valid && beats_in >= pressure_after) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct());
      end
   end

   // Monitor: compare every accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (order_due.size() == 0) begin
            flag_mismatch($sformatf("result beat with nothing pending, position %0d",
                                    rsp_position));
         end else begin
            want = order_due.pop_front();
            if (rsp_position !== want.position)
               flag_mismatch($sformatf("position %0d, predicted %0d",
                                       rsp_position, want.position));
            if (rsp_last_out !== want.last_out)
               flag_mismatch($sformatf("last_out %b, predicted %b at position %0d",
                                       rsp_last_out, want.last_out, want.position));
            if (rsp_overflow !== want.overflow)
               flag_mismatch($sformatf("overflow %b, predicted %b at position %0d",
                                       rsp_overflow, want.overflow, want.position));
         end
      end
   end

   // Watchdog: end the run if no beat moves on either side for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("argsort_index_tiebreak test failed");
      $finish;
   end

   initial begin
      // Directed set: zeros of both signs, infinities, largest finite values,
      // denormals, NaNs of both signs, and ties.
      queue_beat(64'h0000_0000_0000_0000, 1'b0);
      queue_beat(ais_pkg::SignBit, 1'b0);
      queue_beat($realtobits(1.0), 1'b0);
      queue_beat($realtobits(-1.0), 1'b0);
      queue_beat(64'h7FF0_0000_0000_0000, 1'b0);
      queue_beat(64'hFFF0_0000_0000_0000, 1'b0);
      queue_beat($realtobits(1.0), 1'b0);
      queue_beat(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
      queue_beat(64'hFFEF_FFFF_FFFF_FFFF, 1'b0);
      queue_beat(64'h0000_0000_0000_0001, 1'b0);
      queue_beat(64'h8000_0000_0000_0001, 1'b0);
      queue_beat(64'h7FF8_0000_0000_0000, 1'b0);
      queue_beat(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      queue_beat(ais_pkg::SignBit, 1'b1);
      // single-value set, then a set of two equal values
      queue_beat($realtobits(3.5), 1'b1);
      queue_beat($realtobits(-2.5), 1'b0);
      queue_beat($realtobits(-2.5), 1'b1);

      // Random sets, mostly short with some longer ones
      while (value_feed.size() < 200)
         queue_set(($urandom_range(4) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12));
      // exactly full, then overflowing with the last three beats dropped
      queue_set(CAPACITY);
      queue_set(CAPACITY + 3);
      pressure_after = value_feed.size();
      while (value_feed.size() < 380) queue_set($urandom_range(1, 12));

      stage_one_at = value_feed.size() / 3;
      stage_two_at = 2 * value_feed.size() / 3;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Drain: every beat accepted and every predicted position received
      while (value_feed.size() != 0 || req_valid || order_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("argsort_index_tiebreak test passed");
      end else begin
         $display("argsort_index_tiebreak test failed");
      end
      $finish;
   end

endmodule
